>>> design/clut_pkg.sv
// shared types and constants of the color lookup table
package clut_pkg;

  localparam int unsigned LevelsDef   = 64;
  localparam int unsigned ChannelsDef = 7;
  localparam int unsigned NumOut      = 7;
  localparam int unsigned CompW       = 17;
  localparam int unsigned CellW       = 6;
  localparam int unsigned ChanW       = 3;
  localparam int unsigned EntryW      = 16;
  localparam int unsigned WeightW     = 17;
  localparam int unsigned IdxW        = 7;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned OutDepth    = 8;
  localparam int unsigned CreditW     = 4;

  localparam logic [CompW-1:0] OneQ16 = CompW'(65536);

  typedef enum logic {
    CmdWrite   = 1'b0,
    CmdConvert = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                    cmd;
    logic                    wr_en;
    logic [IdxW-1:0]         lo_r;
    logic [IdxW-1:0]         lo_g;
    logic [IdxW-1:0]         lo_b;
    logic [WeightW-1:0]      w_r;
    logic [WeightW-1:0]      w_g;
    logic [WeightW-1:0]      w_b;
    logic [CellW-1:0]        cell_r;
    logic [CellW-1:0]        cell_g;
    logic [CellW-1:0]        cell_b;
    logic [ChanW-1:0]        channel;
    logic [EntryW-1:0]       value;
  } clut_item_t;

  typedef logic [NumOut-1:0][EntryW-1:0] clut_result_t;

endpackage

>>> design/clut_in_if.sv
// input channel of the color lookup table
interface clut_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [16:0] red;
  logic [16:0] green;
  logic [16:0] blue;
  logic [5:0]  cell_red;
  logic [5:0]  cell_green;
  logic [5:0]  cell_blue;
  logic [2:0]  channel;
  logic signed [15:0] entry_value;

  modport source (output valid, cmd, red, green, blue, cell_red, cell_green, cell_blue,
                  channel, entry_value, input ready);
  modport sink (input valid, cmd, red, green, blue, cell_red, cell_green, cell_blue,
                channel, entry_value, output ready);
endinterface

>>> design/clut_out_if.sv
// result channel of the color lookup table
interface clut_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] long_cone;
  logic signed [15:0] mid_cone;
  logic signed [15:0] short_cone;
  logic signed [15:0] long_mid_sum;
  logic signed [15:0] long_vs_mid;
  logic signed [15:0] short_vs_long_mid;
  logic signed [15:0] grey_level;

  modport source (output valid, long_cone, mid_cone, short_cone, long_mid_sum, long_vs_mid,
                  short_vs_long_mid, grey_level, input ready);
  modport sink (input valid, long_cone, mid_cone, short_cone, long_mid_sum, long_vs_mid,
                short_vs_long_mid, grey_level, output ready);
endinterface

>>> design/clut_ram.sv
// generic single port write, single port read ram with registered read
module clut_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> design/clut_fifo.sv
// small register fifo
module clut_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [PtrW:0]   FullCnt = (PtrW + 1)'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? ((wr_q == LastPtr) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop ? ((rd_q == LastPtr) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PtrW + 1)'(do_push) - (PtrW + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule

>>> design/clut_front.sv
// front end: grid mapping of convert items and range check of write items
module clut_front import clut_pkg::*; #(
  parameter int unsigned LEVELS   = LevelsDef,
  parameter int unsigned CHANNELS = ChannelsDef
) (
  clut_in_if.sink    in_i,
  input  logic       full_i,
  output logic       push_o,
  output clut_item_t item_o
);
  localparam logic [IdxW-1:0] TopIdx   = IdxW'(LEVELS - 1);
  localparam logic [IdxW-1:0] LowTop   = IdxW'(LEVELS - 2);
  localparam logic [IdxW:0]   LevelsV  = (IdxW + 1)'(LEVELS);
  localparam logic [ChanW:0]  ChansV   = (ChanW + 1)'(CHANNELS);

  function automatic logic [IdxW+WeightW-1:0] grid_pos(logic [CompW-1:0] v);
    logic [CompW-1:0]      vc;
    logic [CompW+IdxW-1:0] f;
    logic [IdxW:0]         li;
    vc = (v > OneQ16) ? OneQ16 : v;
    f  = vc * TopIdx;
    li = f[CompW+IdxW-1:16];
    if (li >= (IdxW + 1)'(TopIdx)) begin
      return {LowTop, OneQ16};
    end
    return {li[IdxW-1:0], 1'b0, f[15:0]};
  endfunction

  logic in_range;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid;

  assign in_range = ((IdxW + 1)'(in_i.cell_red) < LevelsV)
                 && ((IdxW + 1)'(in_i.cell_green) < LevelsV)
                 && ((IdxW + 1)'(in_i.cell_blue) < LevelsV)
                 && ((ChanW + 1)'(in_i.channel) < ChansV);

  always_comb begin
    item_o.cmd               = cmd_e'(in_i.cmd);
    item_o.wr_en             = (cmd_e'(in_i.cmd) == CmdWrite) && in_range;
    {item_o.lo_r, item_o.w_r} = grid_pos(in_i.red);
    {item_o.lo_g, item_o.w_g} = grid_pos(in_i.green);
    {item_o.lo_b, item_o.w_b} = grid_pos(in_i.blue);
    item_o.cell_r            = in_i.cell_red;
    item_o.cell_g            = in_i.cell_green;
    item_o.cell_b            = in_i.cell_blue;
    item_o.channel           = in_i.channel;
    item_o.value             = in_i.entry_value;
  end
endmodule

>>> design/clut_back.sv
// back end: banked table, interpolation pipeline and result buffer
module clut_back import clut_pkg::*; #(
  parameter int unsigned LEVELS   = LevelsDef,
  parameter int unsigned CHANNELS = ChannelsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  clut_item_t item_i,
  input  logic       empty_i,
  output logic       pop_o,
  clut_out_if.source out_o
);
  localparam int unsigned Half      = (LEVELS + 1) / 2;
  localparam int unsigned BankDepth = Half * Half * Half;
  localparam int unsigned BankAw    = (BankDepth > 1) ? $clog2(BankDepth) : 1;
  localparam int unsigned ExtW      = 3 * IdxW;
  localparam int unsigned OutCh     = (CHANNELS < NumOut) ? CHANNELS : NumOut;
  localparam logic [CreditW-1:0] CreditInit = CreditW'(OutDepth);

  function automatic logic [BankAw-1:0] bank_addr(logic [IdxW-2:0] hr, logic [IdxW-2:0] hg,
                                                  logic [IdxW-2:0] hb);
    logic [ExtW-1:0] a;
    a = (ExtW'(hr) * ExtW'(Half) + ExtW'(hg)) * ExtW'(Half) + ExtW'(hb);
    return a[BankAw-1:0];
  endfunction

  logic [CreditW-1:0] credit_q, credit_d;
  logic issue_conv, out_pop, out_full, out_empty;
  logic [BankAw-1:0] waddr;
  logic [BankAw-1:0] raddr [8];
  logic [EntryW-1:0] rdata [CHANNELS][8];

  logic v1_q, v2_q, v3_q, v4_q;
  logic [WeightW-1:0] w1r_q, w1g_q, w1b_q, w2r_q, w2g_q, w3r_q;
  logic [2:0] par1_q;

  logic signed [32:0] ab_q [OutCh][4];
  logic signed [48:0] ag_q [OutCh][2];
  logic signed [48:0] ag0_q [OutCh];
  logic signed [43:0] ph_q [OutCh];
  logic signed [42:0] pl_q [OutCh];
  clut_result_t res, res_out;

  assign pop_o      = !empty_i && ((item_i.cmd == CmdWrite) || (credit_q != '0));
  assign issue_conv = pop_o && (item_i.cmd == CmdConvert);
  assign out_pop    = out_o.valid && out_o.ready;
  assign credit_d   = credit_q - CreditW'(issue_conv) + CreditW'(out_pop);

  assign waddr = bank_addr((IdxW - 1)'(item_i.cell_r >> 1), (IdxW - 1)'(item_i.cell_g >> 1),
                           (IdxW - 1)'(item_i.cell_b >> 1));

  for (genvar b = 0; b < 8; b++) begin : g_addr
    logic [IdxW-1:0] ir, ig, ib;
    assign ir = item_i.lo_r + IdxW'(b[0] ^ item_i.lo_r[0]);
    assign ig = item_i.lo_g + IdxW'(b[1] ^ item_i.lo_g[0]);
    assign ib = item_i.lo_b + IdxW'(b[2] ^ item_i.lo_b[0]);
    assign raddr[b] = bank_addr(ir[IdxW-1:1], ig[IdxW-1:1], ib[IdxW-1:1]);
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan_ram
    for (genvar b = 0; b < 8; b++) begin : g_bank
      logic we;
      assign we = pop_o && item_i.wr_en && (item_i.channel == ChanW'(c))
               && ({item_i.cell_b[0], item_i.cell_g[0], item_i.cell_r[0]} == 3'(b));
      clut_ram #(.Width(EntryW), .Depth(BankDepth)) u_ram (
        .clk_i   (clk_i),
        .we_i    (we),
        .waddr_i (waddr),
        .wdata_i (item_i.value),
        .raddr_i (raddr[b]),
        .rdata_o (rdata[c][b])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= CreditInit;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
    end else begin
      credit_q <= credit_d;
      v1_q     <= issue_conv;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w1r_q  <= item_i.w_r;
    w1g_q  <= item_i.w_g;
    w1b_q  <= item_i.w_b;
    par1_q <= {item_i.lo_b[0], item_i.lo_g[0], item_i.lo_r[0]};
    w2r_q  <= w1r_q;
    w2g_q  <= w1g_q;
    w3r_q  <= w2r_q;
  end

  for (genvar c = 0; c < OutCh; c++) begin : g_lerp
    logic signed [17:0] wb_s, wg_s, wr_s;
    logic signed [65:0] sum;
    assign wb_s = $signed({1'b0, w1b_q});
    assign wg_s = $signed({1'b0, w2g_q});
    assign wr_s = $signed({1'b0, w3r_q});

    // blue lerp, one per red/green corner pair
    for (genvar j = 0; j < 4; j++) begin : g_b
      logic signed [15:0] e0, e1;
      logic signed [16:0] d;
      logic signed [34:0] p;
      assign e0 = $signed(rdata[c][3'(j) ^ par1_q]);
      assign e1 = $signed(rdata[c][3'(j + 4) ^ par1_q]);
      assign d  = 17'(e1) - 17'(e0);
      assign p  = 35'(d) * 35'(wb_s);
      always_ff @(posedge clk_i) begin
        ab_q[c][j] <= 33'((35'(e0) <<< 16) + p);
      end
    end

    // green lerp
    for (genvar i = 0; i < 2; i++) begin : g_g
      logic signed [33:0] d;
      logic signed [51:0] p;
      assign d = 34'(ab_q[c][i + 2]) - 34'(ab_q[c][i]);
      assign p = 52'(d) * 52'(wg_s);
      always_ff @(posedge clk_i) begin
        ag_q[c][i] <= 49'((52'(ab_q[c][i]) <<< 16) + p);
      end
    end

    // red lerp split into two partial products
    if (1) begin : g_r
      logic signed [49:0] d;
      logic signed [25:0] dh;
      logic signed [24:0] dl;
      assign d  = 50'(ag_q[c][1]) - 50'(ag_q[c][0]);
      assign dh = d[49:24];
      assign dl = $signed({1'b0, d[23:0]});
      always_ff @(posedge clk_i) begin
        ph_q[c]  <= 44'(dh) * 44'(wr_s);
        pl_q[c]  <= 43'(dl) * 43'(wr_s);
        ag0_q[c] <= ag_q[c][0];
      end
    end

    assign sum = (66'(ag0_q[c]) <<< 16) + (66'(ph_q[c]) <<< 24) + 66'(pl_q[c])
               + (66'(1) <<< 47);
    assign res[c] = sum[63:48];
  end

  for (genvar c = OutCh; c < NumOut; c++) begin : g_zero
    assign res[c] = '0;
  end

  clut_fifo #(.Width($bits(clut_result_t)), .Depth(OutDepth)) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (v4_q),
    .data_i  (res),
    .full_o  (out_full),
    .pop_i   (out_o.ready),
    .data_o  (res_out),
    .empty_o (out_empty)
  );

  assign out_o.valid             = !out_empty && !(out_full && 1'b0);
  assign out_o.long_cone         = $signed(res_out[0]);
  assign out_o.mid_cone          = $signed(res_out[1]);
  assign out_o.short_cone        = $signed(res_out[2]);
  assign out_o.long_mid_sum      = $signed(res_out[3]);
  assign out_o.long_vs_mid       = $signed(res_out[4]);
  assign out_o.short_vs_long_mid = $signed(res_out[5]);
  assign out_o.grey_level        = $signed(res_out[6]);
endmodule

>>> design/color_lut_trilinear_interp.sv
// top level of the 3d color lookup table with trilinear interpolation
//
// in_i carries write items (cmd 0: store entry_value at cell and channel) and
// convert items (cmd 1: red, green, blue in q1.16). out_o carries one result of
// seven interpolated channels for each convert item, in order; writes give none.
// Both channels use valid/ready; an item moves when both are high.
// The table is split into eight banks per channel by the parity of the grid
// index on each axis, so all eight corners of a cell are read in the same cycle.
// Throughput is one item per cycle unless a stalled out_o holds back convert
// items. A convert result passes through the input queue, bank read, then blue,
// green and red lerp stages and the result buffer, each registered.
// A convert item is issued from the input queue only while the result buffer
// holds a free slot for it, so a stalled receiver fills the buffer, then the
// queue, and then ready on in_i drops; nothing is lost.
// Reset clears the queues and the pipeline; table contents are not cleared and
// a cell must be written before a convert item reads it.
module color_lut_trilinear_interp import clut_pkg::*; #(
  parameter int unsigned LEVELS   = LevelsDef,
  parameter int unsigned CHANNELS = ChannelsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  clut_in_if.sink    in_i,
  clut_out_if.source out_o
);
  clut_item_t item_in, item_q;
  logic push, q_full, q_empty, q_pop;

  clut_front #(.LEVELS(LEVELS), .CHANNELS(CHANNELS)) u_front (
    .in_i   (in_i),
    .full_i (q_full),
    .push_o (push),
    .item_o (item_in)
  );

  clut_fifo #(.Width($bits(clut_item_t)), .Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (item_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (item_q),
    .empty_o (q_empty)
  );

  clut_back #(.LEVELS(LEVELS), .CHANNELS(CHANNELS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_q),
    .empty_i (q_empty),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );
endmodule

>>> design/clut_checker.sv
// port checker of the color lookup table and its bind
module clut_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_cmd_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [15:0] out_long_i
);
  logic [7:0] pend_q, pend_d;
  logic in_conv, out_acc;

  assign in_conv = in_valid_i && in_ready_i && in_cmd_i;
  assign out_acc = out_valid_i && out_ready_i;
  assign pend_d  = pend_q + 8'(in_conv) - 8'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pend_q != '0))
    else $error("result without pending convert item");

  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_conv && pend_q == '0) |=> !out_valid_i)
    else $error("result too early");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_long_i)))
    else $error("stalled result changed");
endmodule

bind color_lut_trilinear_interp clut_checker u_clut_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_cmd_i    (in_i.cmd),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_long_i  (out_o.long_cone)
);

>>> test/tb_color_lut_trilinear_interp.sv
// testbench for the 3d color lookup table with trilinear interpolation
`timescale 1ns / 1ps

module tb_color_lut_trilinear_interp;
  import clut_pkg::*;

  localparam int unsigned TotalItems = 1950;

  class lut_scoreboard;
    logic [EntryW-1:0] lut_mem [int];
    clut_result_t      pending_q [$];
    int                errors;
    int                checked;
    string             chan_names [NumOut] = '{"long_cone", "mid_cone", "short_cone",
                                               "long_mid_sum", "long_vs_mid",
                                               "short_vs_long_mid", "grey_level"};

    function int cell_addr(int ch, int r, int g, int b);
      return ((ch * LevelsDef + r) * LevelsDef + g) * LevelsDef + b;
    endfunction

    function bit is_written(int ch, int r, int g, int b);
      return lut_mem.exists(cell_addr(ch, r, g, b));
    endfunction

    function void note_write(int ch, int r, int g, int b, logic [EntryW-1:0] val);
      if (ch < ChannelsDef) lut_mem[cell_addr(ch, r, g, b)] = val;
    endfunction

    function void grid_map(logic [CompW-1:0] v, output int lo, output longint wt);
      longint f;
      f = longint'((v > OneQ16) ? OneQ16 : v) * (LevelsDef - 1);
      if ((f >> 16) >= LevelsDef - 1) begin
        lo = LevelsDef - 2;
        wt = 65536;
      end else begin
        lo = int'(f >> 16);
        wt = f & 64'hFFFF;
      end
    endfunction

    function void note_convert(logic [CompW-1:0] r, logic [CompW-1:0] g,
                               logic [CompW-1:0] b);
      int           lo [3];
      longint       wt [3];
      longint       acc, w, e;
      clut_result_t res;
      logic [EntryW-1:0] raw;
      grid_map(r, lo[0], wt[0]);
      grid_map(g, lo[1], wt[1]);
      grid_map(b, lo[2], wt[2]);
      for (int ch = 0; ch < NumOut; ch++) begin
        acc = 0;
        for (int c = 0; c < 8; c++) begin
          w = (c[0] ? wt[0] : 65536 - wt[0]) * (c[1] ? wt[1] : 65536 - wt[1])
              * (c[2] ? wt[2] : 65536 - wt[2]);
          raw = lut_mem[cell_addr(ch, lo[0] + c[0], lo[1] + c[1], lo[2] + c[2])];
          e = longint'($signed(raw));
          acc += e * w;
        end
        res[ch] = EntryW'((acc + (64'sd1 <<< 47)) >>> 48);
      end
      pending_q.push_back(res);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(clut_result_t got);
      clut_result_t want;
      if (pending_q.size() == 0) begin
        report("result with no convert item outstanding");
        return;
      end
      want = pending_q.pop_front();
      checked++;
      for (int ch = 0; ch < NumOut; ch++)
        if (got[ch] !== want[ch])
          report($sformatf("%s got %0d want %0d", chan_names[ch],
                           $signed(got[ch]), $signed(want[ch])));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  clut_in_if  in_if ();
  clut_out_if out_if ();

  color_lut_trilinear_interp dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  lut_scoreboard sb = new();
  int idle_pct  = 0;
  int stall_pct = 0;
  int sent      = 0;
  int writes    = 0;
  int converts  = 0;
  int cube_q [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_if.valid       = 1'b0;
    in_if.cmd         = CmdWrite;
    in_if.red         = '0;
    in_if.green       = '0;
    in_if.blue        = '0;
    in_if.cell_red    = '0;
    in_if.cell_green  = '0;
    in_if.cell_blue   = '0;
    in_if.channel     = '0;
    in_if.entry_value = '0;
    out_if.ready      = 1'b0;
  end

  always @(posedge clk_i) begin
    clut_result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got[0] = out_if.long_cone;
      got[1] = out_if.mid_cone;
      got[2] = out_if.short_cone;
      got[3] = out_if.long_mid_sum;
      got[4] = out_if.long_vs_mid;
      got[5] = out_if.short_vs_long_mid;
      got[6] = out_if.grey_level;
      sb.check_result(got);
    end
    out_if.ready <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  task send_item(cmd_e cmd, logic [16:0] r, logic [16:0] g, logic [16:0] b,
                 logic [5:0] cr, logic [5:0] cg, logic [5:0] cb, logic [2:0] ch,
                 logic [15:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= cmd;
    in_if.red         <= r;
    in_if.green       <= g;
    in_if.blue        <= b;
    in_if.cell_red    <= cr;
    in_if.cell_green  <= cg;
    in_if.cell_blue   <= cb;
    in_if.channel     <= ch;
    in_if.entry_value <= val;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (cmd == CmdWrite) begin
      sb.note_write(ch, cr, cg, cb, val);
      if (ch < ChannelsDef) begin
        writes++;
        sent++;
      end
    end else begin
      sb.note_convert(r, g, b);
      converts++;
      sent++;
    end
  endtask

  task write_entry(int ch, int r, int g, int b, logic [15:0] val);
    send_item(CmdWrite, 17'($urandom), 17'($urandom), 17'($urandom),
              6'(r), 6'(g), 6'(b), 3'(ch), val);
  endtask

  task convert_pixel(logic [16:0] r, logic [16:0] g, logic [16:0] b);
    send_item(CmdConvert, r, g, b, 6'($urandom), 6'($urandom), 6'($urandom),
              3'($urandom), 16'($urandom));
  endtask

  // make all eight corners of the cube at (lr, lg, lb) readable
  task fill_cube(int lr, int lg, int lb, bit extremes);
    logic [15:0] val;
    if ($urandom_range(3) == 0)
      write_entry(ChannelsDef, lr, lg, lb, 16'($urandom));
    for (int c = 0; c < 8; c++)
      for (int ch = 0; ch < ChannelsDef; ch++)
        if (!sb.is_written(ch, lr + c[0], lg + c[1], lb + c[2]) || $urandom_range(3) == 0) begin
          case ($urandom_range(extremes ? 3 : 9))
            0: val = 16'h8000;
            1: val = 16'h7FFF;
            2: val = 16'hFFFF;
            3: val = 16'h0000;
            default: val = 16'($urandom);
          endcase
          write_entry(ch, lr + c[0], lg + c[1], lb + c[2], val);
        end
    cube_q.push_back((lr << 12) | (lg << 6) | lb);
  endtask

  // component value whose lower grid index is lo
  function logic [16:0] comp_at(int lo);
    int lo_v, hi_v;
    lo_v = (lo * 65536 + 62) / 63;
    hi_v = ((lo + 1) * 65536 + 62) / 63 - 1;
    if (lo == LevelsDef - 2) begin
      hi_v = 131071;
      if ($urandom_range(3) == 0) return 17'(65536);
    end
    case ($urandom_range(7))
      0: return 17'(lo_v);
      1: return 17'(hi_v);
      default: return 17'($urandom_range(hi_v, lo_v));
    endcase
  endfunction

  task random_convert();
    int cube;
    cube = cube_q[$urandom_range(cube_q.size() - 1)];
    convert_pixel(comp_at((cube >> 12) & 63), comp_at((cube >> 6) & 63), comp_at(cube & 63));
  endtask

  task random_step();
    int e;
    if (cube_q.size() == 0 || $urandom_range(24) == 0) begin
      e = $urandom_range(3);
      fill_cube(e == 0 ? 0 : e == 1 ? 62 : $urandom_range(62),
                $urandom_range(1) ? $urandom_range(62) : 62 * $urandom_range(1),
                $urandom_range(62), 1'b0);
    end else begin
      random_convert();
    end
  endtask

  task drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fill_cube(0, 0, 0, 1'b1);
    fill_cube(62, 62, 62, 1'b1);
    fill_cube(0, 62, 31, 1'b1);
    convert_pixel(17'd0, 17'd0, 17'd0);
    convert_pixel(17'd65536, 17'd65536, 17'd65536);
    convert_pixel(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    convert_pixel(17'd70000, 17'd65535, 17'd131000);
    convert_pixel(17'd1040, 17'd1040, 17'd1040);
    convert_pixel(17'd1, 17'd0, 17'd1039);
    convert_pixel(17'd0, 17'd65536, 17'd32300);
    convert_pixel(17'd1040, 17'd66000, 17'd32767);
    convert_pixel(17'd64520, 17'd65535, 17'd64521);
    drain();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = (p == 1) ? 81 : (p == 3) ? 25 : 0;
      stall_pct = (p == 2) ? 81 : (p == 3) ? 25 : 0;
      while (sent < (p + 1) * TotalItems / 4) random_step();
      drain();
    end

    $display("covered %0d table writes and %0d pixel conversions over %0d cubes,",
             writes, converts, cube_q.size());
    $display("%0d results checked under four sender and receiver pacing phases",
             sb.checked);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", sb.pending_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
